@@ src/work_stealing_task_table_core_defines.svh @@
// ----------------------------------------------------------------------------
// Work-stealing task table: assertion macros
// Concurrent checks on clk, disabled while rst is high; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef WORK_STEALING_TASK_TABLE_CORE_DEFINES_SVH
`define WORK_STEALING_TASK_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle.
`define WSTT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("work stealing task table: check failed");
// Check that a condition implies another in the next cycle.
`define WSTT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("work stealing task table: check failed");
`else
`define WSTT_ASSERT_IMP(label, ante, cons)
`define WSTT_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ src/wstt_pkg.sv @@
// ----------------------------------------------------------------------------
// Work-stealing task table: package
// Command, status, flag and register codes, and the per-rank entry type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wstt_pkg;

  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_NEXT  = 3'd1;
  localparam logic [2:0] CMD_PEER  = 3'd2;
  localparam logic [2:0] CMD_HELP  = 3'd3;
  localparam logic [2:0] CMD_RECV  = 3'd4;
  localparam logic [2:0] CMD_SHAKE = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [2:0] FL_FOREIGN = 3'd0;
  localparam logic [2:0] FL_PENDING = 3'd1;
  localparam logic [2:0] FL_DONE    = 3'd2;
  localparam logic [2:0] FL_HELPED  = 3'd3;
  localparam logic [2:0] FL_OFFERED = 3'd4;

  localparam logic [1:0] CFG_OWN_RANK  = 2'd0;
  localparam logic [1:0] CFG_ROWS      = 2'd1;
  localparam logic [1:0] CFG_COLS_RANK = 2'd2;
  localparam logic [1:0] CFG_RANKS     = 2'd3;

  localparam logic [10:0] CNT_MAX = 11'd2047;

  typedef struct packed {
    logic [10:0] count;
    logic [3:0]  row;
    logic [5:0]  col;
  } rank_entry_t;

endpackage

`default_nettype wire

@@ src/work_stealing_task_table_core.sv @@
// ----------------------------------------------------------------------------
// Work-stealing task table core
// Task flag grid and per-rank progress, driven by one small sequencer.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to transfer one command; exactly one result
// follows, shown for one cycle with done high, and it cannot be held off, so
// capture it on that cycle. Each command first loads this rank's entry
// (S_LOAD, S_OWN) and then dispatches (S_DISP); then: start writes one own
// cell a cycle (rows in use times cols_per_rank, clipped to the grid), next
// scans the flag memory column by column at one cell a cycle, a help query
// sweeps the rank table at one rank a cycle, help received and handshake
// read the named cell (S_CELL) and end there, and peer status and unknown
// commands end at dispatch.
// The flag memory read port and the rank table read port set these rates.
// After reset the block stays busy while it clears the flag memory;
// configuration writes are taken at any time and cfg_ready is
// always high, but write only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "work_stealing_task_table_core_defines.svh"

module work_stealing_task_table_core
  import wstt_pkg::*;
#(
  parameter int ROWS  = 16,
  parameter int COLS  = 64,
  parameter int RANKS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  cmd,
  input  wire logic [2:0]  peer_rank,
  input  wire logic [10:0] peer_count,
  input  wire logic [3:0]  cell_row,
  input  wire logic [5:0]  cell_col,
  output logic             done,
  output logic [1:0]       status,
  output logic [2:0]       target_rank,
  output logic [3:0]       target_row,
  output logic [5:0]       target_col,
  output logic [10:0]      own_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RKW   = (RANKS > 1) ? $clog2(RANKS) : 1;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LOAD   = 4'd2;
  localparam logic [3:0] S_OWN    = 4'd3;
  localparam logic [3:0] S_DISP   = 4'd4;
  localparam logic [3:0] S_FILL   = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_SWEEP  = 4'd7;
  localparam logic [3:0] S_DECIDE = 4'd8;
  localparam logic [3:0] S_HELP   = 4'd9;
  localparam logic [3:0] S_CELL   = 4'd10;

  function automatic logic [AW-1:0] cell_addr(input logic [10:0] r, input logic [10:0] c);
    cell_addr = AW'(32'(r) * COLS + 32'(c));
  endfunction

  // Configuration registers.
  logic [2:0] own_rank;
  logic [4:0] rows_in_use;
  logic [6:0] cols_per_rank;
  logic [3:0] ranks_in_use;

  // Sequencer and captured command.
  logic [3:0]    state;
  logic [AW-1:0] clr_addr;
  logic [2:0]    cmd_r;
  logic [2:0]    peer_rank_r;
  logic [10:0]   peer_count_r;
  logic [3:0]    cell_row_r;
  logic [5:0]    cell_col_r;
  logic [10:0]   own_cnt;
  logic [3:0]    own_row;
  logic [5:0]    own_col;

  // Walk counters shared by fill and scan, the fill end and the scan check.
  logic [4:0]  row_i;
  logic [10:0] col_j;
  logic [10:0] fill_end;
  logic        chk_valid;
  logic [4:0]  chk_row;
  logic [10:0] chk_col;

  // Rank sweep.
  logic [RKW:0]   sw_r;
  logic           sw_chk;
  logic [RKW-1:0] sw_idx;
  logic [10:0]    mn;
  logic [10:0]    mx;
  logic [RKW-1:0] h;

  // Flag memory.
  logic [2:0]    flags [DEPTH];
  logic          fl_we;
  logic [AW-1:0] fl_wa;
  logic [2:0]    fl_wd;
  logic [AW-1:0] fl_ra;
  logic [2:0]    fl_rd;

  // Rank table; an entry never written reads as zero.
  rank_entry_t    ranks [RANKS];
  logic [RANKS-1:0] rank_valid;
  logic           rk_we;
  logic [RKW-1:0] rk_wa;
  rank_entry_t    rk_wd;
  logic [RKW-1:0] rk_ra;
  rank_entry_t    rk_rd;
  logic           rk_rd_v;
  rank_entry_t    rk_eff;

  // Effective sizes.
  logic [2:0]  me;
  logic [4:0]  nx;
  logic [6:0]  p;
  logic [13:0] np_p;
  logic [10:0] ny;
  logic [9:0]  c0;
  logic [10:0] c_end;
  logic        too_wide;
  logic        last_cell;
  logic        in_tab;
  logic        peer_ok;
  logic [10:0] cnt_inc;
  logic        found;
  logic        walk_wrap;

  // Help candidate.
  logic [4:0]  rr;
  logic [6:0]  cc;
  logic        help_ok;
  logic [1:0]  help_st;

  // Finish decision.
  logic        fin;
  logic [1:0]  fin_st;
  logic [2:0]  fin_rank;
  logic [3:0]  fin_row;
  logic [5:0]  fin_col;
  logic [10:0] fin_cnt;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    me       = (32'(own_rank) < RANKS) ? own_rank : 3'(RANKS - 1);
    nx       = (32'(rows_in_use) < ROWS) ? rows_in_use : 5'(ROWS);
    p        = (32'(ranks_in_use) < RANKS) ? 7'(ranks_in_use) : 7'(RANKS);
    np_p     = 14'(cols_per_rank) * 14'(p);
    ny       = (32'(np_p) < COLS) ? 11'(np_p) : 11'(COLS);
    too_wide = (32'(np_p) > COLS);
    c0       = 10'(cols_per_rank) * 10'(me);
    c_end    = 11'(c0) + 11'(cols_per_rank);
    last_cell = ((5'(own_row) + 5'd1) == nx) &&
                ((11'(own_col) + 11'd1) == (11'(cols_per_rank) * (11'(me) + 11'd1)));
    in_tab   = (32'(cell_row_r) < ROWS) && (32'(cell_col_r) < COLS);
    peer_ok  = (32'(peer_rank_r) < RANKS) && (peer_rank_r != me);
    cnt_inc  = (own_cnt == CNT_MAX) ? own_cnt : own_cnt + 11'd1;
    found    = chk_valid && (fl_rd == FL_PENDING);
    walk_wrap = ((row_i + 5'd1) == nx);
    rk_eff   = rk_rd_v ? rk_rd : '0;
  end

  // Help candidate: next row of the target rank, else the top of its next column.
  always_comb begin
    rr      = '0;
    cc      = '0;
    help_ok = 1'b0;
    help_st = ST_ERR;
    if ((5'(rk_eff.row) + 5'd1) < nx) begin
      rr      = 5'(rk_eff.row) + 5'd1;
      cc      = 7'(rk_eff.col);
      help_ok = 1'b1;
      help_st = ST_OK;
    end else if ((11'(rk_eff.col) + 11'd1) < ny) begin
      cc      = 7'(rk_eff.col) + 7'd1;
      help_ok = 1'b1;
      help_st = ST_OK;
    end else if ((5'(rk_eff.row) + 5'd1) == nx) begin
      help_st = ST_NONE;
    end
  end

  // Finish decision per state.
  always_comb begin
    fin      = 1'b0;
    fin_st   = ST_NONE;
    fin_rank = '0;
    fin_row  = '0;
    fin_col  = '0;
    fin_cnt  = own_cnt;
    case (state)
      S_DISP: begin
        case (cmd_r)
          CMD_START: begin
            fin    = too_wide || (nx == 5'd0) || (cols_per_rank == 7'd0) ||
                     (32'(c0) >= COLS);
            fin_st = too_wide ? ST_ERR : ST_OK;
          end
          CMD_NEXT: begin
            fin    = (nx == 5'd0) || (ny == 11'd0);
            fin_st = ST_NONE;
          end
          CMD_PEER: begin
            fin    = 1'b1;
            fin_st = peer_ok ? ST_OK : ST_NONE;
          end
          CMD_HELP: begin
            fin    = last_cell || (p == 7'd0);
            fin_st = ST_NONE;
          end
          CMD_RECV: begin
            fin    = !in_tab;
            fin_st = ST_ERR;
          end
          CMD_SHAKE: begin
            fin    = !in_tab;
            fin_st = ST_NONE;
          end
          default: begin
            fin    = 1'b1;
            fin_st = ST_ERR;
          end
        endcase
      end
      S_FILL: begin
        fin    = walk_wrap && ((col_j + 11'd1) == fill_end);
        fin_st = ST_OK;
      end
      S_SCAN: begin
        if (found) begin
          fin     = 1'b1;
          fin_st  = ST_OK;
          fin_row = chk_row[3:0];
          fin_col = chk_col[5:0];
          fin_cnt = cnt_inc;
        end else if (col_j >= ny) begin
          fin    = 1'b1;
          fin_st = ST_NONE;
        end
      end
      S_DECIDE: begin
        fin    = !((12'(mx) >= (12'(mn) + 12'd2)) && (own_cnt == mx));
        fin_st = ST_NONE;
      end
      S_HELP: begin
        fin    = 1'b1;
        fin_st = help_st;
        if (help_ok) begin
          fin_rank = 3'(h);
          fin_row  = rr[3:0];
          fin_col  = cc[5:0];
        end
      end
      S_CELL: begin
        fin = 1'b1;
        if (cmd_r == CMD_RECV) begin
          if (fl_rd == FL_PENDING) begin
            fin_st  = ST_OK;
            fin_cnt = cnt_inc;
          end else if (fl_rd == FL_FOREIGN) begin
            fin_st = ST_ERR;
          end
        end else if ((fl_rd == FL_FOREIGN) || (fl_rd == FL_OFFERED)) begin
          fin_st = ST_OK;
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  // Memory port selection.
  always_comb begin
    fl_we = 1'b0;
    fl_wa = cell_addr(11'(cell_row_r), 11'(cell_col_r));
    fl_wd = FL_PENDING;
    fl_ra = cell_addr(11'(cell_row_r), 11'(cell_col_r));
    rk_we = 1'b0;
    rk_wa = RKW'(me);
    rk_wd = '{count: cnt_inc, row: own_row, col: own_col};
    rk_ra = RKW'(me);
    case (state)
      S_CLEAR: begin
        fl_we = 1'b1;
        fl_wa = clr_addr;
        fl_wd = FL_FOREIGN;
      end
      S_DISP: begin
        if ((cmd_r == CMD_PEER) && peer_ok) begin
          rk_we = 1'b1;
          rk_wa = RKW'(peer_rank_r);
          rk_wd = '{count: peer_count_r, row: cell_row_r, col: cell_col_r};
        end
      end
      S_FILL: begin
        fl_we = 1'b1;
        fl_wa = cell_addr(11'(row_i), col_j);
        fl_wd = FL_PENDING;
      end
      S_SCAN: begin
        fl_ra = cell_addr(11'(row_i), col_j);
        if (found) begin
          fl_we = 1'b1;
          fl_wa = cell_addr(11'(chk_row), chk_col);
          fl_wd = FL_DONE;
          rk_we = 1'b1;
          rk_wd = '{count: cnt_inc, row: chk_row[3:0], col: chk_col[5:0]};
        end
      end
      S_SWEEP: begin
        rk_ra = sw_r[RKW-1:0];
      end
      S_DECIDE: begin
        rk_ra = h;
      end
      S_HELP: begin
        if (help_ok && (32'(rr) < ROWS) && (32'(cc) < COLS)) begin
          fl_we = 1'b1;
          fl_wa = cell_addr(11'(rr), 11'(cc));
          fl_wd = FL_OFFERED;
        end
      end
      S_CELL: begin
        if (cmd_r == CMD_RECV) begin
          if (fl_rd == FL_PENDING) begin
            fl_we = 1'b1;
            fl_wd = FL_HELPED;
            rk_we = 1'b1;
          end
        end else if ((fl_rd == FL_FOREIGN) || (fl_rd == FL_OFFERED)) begin
          fl_we = 1'b1;
          fl_wd = FL_PENDING;
        end
      end
      default: begin
        fl_we = 1'b0;
      end
    endcase
  end

  // Flag memory, registered read.
  always_ff @(posedge clk) begin
    if (fl_we) begin
      flags[fl_wa] <= fl_wd;
    end
    fl_rd <= flags[fl_ra];
  end

  // Rank table, registered read.
  always_ff @(posedge clk) begin
    if (rk_we) begin
      ranks[rk_wa] <= rk_wd;
    end
    rk_rd <= ranks[rk_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_valid <= '0;
      rk_rd_v    <= 1'b0;
    end else begin
      if (rk_we) begin
        rank_valid[rk_wa] <= 1'b1;
      end
      rk_rd_v <= rank_valid[rk_ra];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      done          <= 1'b0;
      chk_valid     <= 1'b0;
      sw_chk        <= 1'b0;
      own_rank      <= 3'd0;
      rows_in_use   <= 5'd16;
      cols_per_rank <= 7'd8;
      ranks_in_use  <= 4'd8;
    end else begin
      done <= 1'b0;

      // Take configuration writes.
      if (cfg_valid) begin
        case (cfg_index)
          CFG_OWN_RANK:  own_rank      <= cfg_data[2:0];
          CFG_ROWS:      rows_in_use   <= cfg_data[4:0];
          CFG_COLS_RANK: cols_per_rank <= cfg_data;
          CFG_RANKS:     ranks_in_use  <= cfg_data[3:0];
          default:       own_rank      <= own_rank;
        endcase
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_r        <= cmd;
            peer_rank_r  <= peer_rank;
            peer_count_r <= peer_count;
            cell_row_r   <= cell_row;
            cell_col_r   <= cell_col;
            state        <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_OWN;
        end
        S_OWN: begin
          own_cnt <= rk_eff.count;
          own_row <= rk_eff.row;
          own_col <= rk_eff.col;
          state   <= S_DISP;
        end
        S_DISP: begin
          row_i     <= '0;
          col_j     <= '0;
          chk_valid <= 1'b0;
          sw_r      <= '0;
          sw_chk    <= 1'b0;
          mn        <= CNT_MAX;
          mx        <= '0;
          h         <= '0;
          case (cmd_r)
            CMD_START: begin
              col_j    <= 11'(c0);
              fill_end <= (32'(c_end) < COLS) ? c_end : 11'(COLS);
              state    <= S_FILL;
            end
            CMD_NEXT:  state <= S_SCAN;
            CMD_HELP:  state <= S_SWEEP;
            default:   state <= S_CELL;
          endcase
        end
        S_FILL: begin
          // Advance column-major over the own block.
          if (walk_wrap) begin
            row_i <= '0;
            col_j <= col_j + 11'd1;
          end else begin
            row_i <= row_i + 5'd1;
          end
        end
        S_SCAN: begin
          // Issue one read a cycle; check the cell read the cycle before.
          chk_valid <= 1'b0;
          if (col_j < ny) begin
            chk_valid <= 1'b1;
            chk_row   <= row_i;
            chk_col   <= col_j;
            if (walk_wrap) begin
              row_i <= '0;
              col_j <= col_j + 11'd1;
            end else begin
              row_i <= row_i + 5'd1;
            end
          end
        end
        S_SWEEP: begin
          // Strict compares keep the first rank holding the minimum.
          if (sw_chk) begin
            if (rk_eff.count < mn) begin
              mn <= rk_eff.count;
              h  <= sw_idx;
            end
            if (rk_eff.count > mx) begin
              mx <= rk_eff.count;
            end
          end
          if (32'(sw_r) < 32'(p)) begin
            sw_chk <= 1'b1;
            sw_idx <= sw_r[RKW-1:0];
            sw_r   <= sw_r + (RKW + 1)'(1);
          end else begin
            sw_chk <= 1'b0;
            state  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= S_HELP;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Drop to idle and show the result.
      if (fin) begin
        state       <= S_IDLE;
        done        <= 1'b1;
        status      <= fin_st;
        target_rank <= fin_rank;
        target_row  <= fin_row;
        target_col  <= fin_col;
        own_count   <= fin_cnt;
      end
    end
  end

  `WSTT_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `WSTT_ASSERT_IMP(a_done_after_work, done, $past(busy))
  `WSTT_ASSERT_NXT(a_done_single, done, !done)
  `WSTT_ASSERT_IMP(a_status_code, done,
                   (status == ST_OK) || (status == ST_NONE) || (status == ST_ERR))
  `WSTT_ASSERT_IMP(a_fail_zero, done && (status != ST_OK),
                   (target_rank == 3'd0) && (target_row == 4'd0) && (target_col == 6'd0))

endmodule

`default_nettype wire
